/* rtl/slf_pkg.sv */
// ----------------------------------------------------------------------------
// slf_pkg: shared types, constants and functions of the status light flasher
// Holds the beat payloads, mode and register codes, colour set and the
// WS2812 symbol encoder.
// ----------------------------------------------------------------------------
package slf_pkg;

  // Strip size and derived widths
  localparam int unsigned LedCount   = 8;
  localparam int unsigned LedCntW    = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // Register reset values
  localparam logic [15:0] DriveIntervalRst = 16'd200;
  localparam logic [15:0] EmergOnWaitRst   = 16'd200;
  localparam logic [15:0] EmergOffWaitRst  = 16'd80;

  // Line symbols for one and zero bits
  localparam logic [2:0] SymOne  = 3'b110;
  localparam logic [2:0] SymZero = 3'b100;

  // Colour bytes
  localparam logic [7:0] YellowRed   = 8'd230;
  localparam logic [7:0] YellowGreen = 8'd1;
  localparam logic [7:0] BlueGreen   = 8'd200;
  localparam logic [7:0] BlueBlue    = 8'd255;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_READY    = 3'd1,
    MODE_DRIVING  = 3'd2,
    MODE_EMERG    = 3'd3,
    MODE_FINISHED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_DRIVE_INTERVAL = 2'd0,
    CFG_EMERG_ON_WAIT  = 2'd1,
    CFG_EMERG_OFF_WAIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    COL_DARK   = 2'd0,
    COL_YELLOW = 2'd1,
    COL_BLUE   = 2'd2
  } colour_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] timer_now;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  led_index;
    logic [23:0] green_code;
    logic [23:0] red_code;
    logic [23:0] blue_code;
    logic        last_led;
  } out_item_t;

  // Refresh request from front to queue
  typedef struct packed {
    logic    push;
    colour_e colour;
  } frame_req_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic    valid;
    colour_e colour;
  } frame_head_t;

  typedef struct packed {
    logic [23:0] green;
    logic [23:0] red;
    logic [23:0] blue;
  } grb_code_t;

  // Encode one byte MSB first as eight 3-bit symbols
  function automatic logic [23:0] encode_byte(logic [7:0] b);
    logic [23:0] code;
    code = '0;
    for (int i = 0; i < 8; i++) begin
      code[3*i +: 3] = b[i] ? SymOne : SymZero;
    end
    return code;
  endfunction

  // Encoded colour words for each colour of the set
  function automatic grb_code_t colour_codes(colour_e c);
    grb_code_t w;
    unique case (c)
      COL_YELLOW: begin
        w.green = encode_byte(YellowGreen);
        w.red   = encode_byte(YellowRed);
        w.blue  = encode_byte(8'd0);
      end
      COL_BLUE: begin
        w.green = encode_byte(BlueGreen);
        w.red   = encode_byte(8'd0);
        w.blue  = encode_byte(BlueBlue);
      end
      default: begin
        w.green = encode_byte(8'd0);
        w.red   = encode_byte(8'd0);
        w.blue  = encode_byte(8'd0);
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/slf_front.sv */
// ----------------------------------------------------------------------------
// slf_front: mode decoder and flash timing
// Accepts input beats, decides whether a refresh is due, keeps the flash
// phase and last update time, and holds the timing registers.
// ----------------------------------------------------------------------------
module slf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  slf_pkg::in_item_t   in_data_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output slf_pkg::frame_req_t req_o
);

  logic [15:0] drive_interval_q, emerg_on_wait_q, emerg_off_wait_q;
  logic [15:0] last_update_q, last_update_d;
  logic        flash_phase_q, flash_phase_d;
  logic [15:0] elapsed;
  logic        accept;
  logic        fire;
  logic        toggle;
  slf_pkg::colour_e colour;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign elapsed    = in_data_i.timer_now - last_update_q;

  // Decide refresh and colour for the current beat
  always_comb begin
    fire   = 1'b0;
    toggle = 1'b0;
    colour = slf_pkg::COL_DARK;
    unique case (in_data_i.mode)
      slf_pkg::MODE_OFF: begin
        fire = 1'b1;
      end
      slf_pkg::MODE_READY: begin
        fire   = 1'b1;
        colour = slf_pkg::COL_YELLOW;
      end
      slf_pkg::MODE_DRIVING: begin
        if (elapsed > drive_interval_q) begin
          fire   = 1'b1;
          toggle = 1'b1;
          colour = flash_phase_q ? slf_pkg::COL_DARK : slf_pkg::COL_YELLOW;
        end
      end
      slf_pkg::MODE_EMERG: begin
        if (!flash_phase_q && (elapsed > emerg_on_wait_q)) begin
          fire   = 1'b1;
          toggle = 1'b1;
          colour = slf_pkg::COL_BLUE;
        end else if (flash_phase_q && (elapsed > emerg_off_wait_q)) begin
          fire   = 1'b1;
          toggle = 1'b1;
        end
      end
      slf_pkg::MODE_FINISHED: begin
        if (elapsed > 16'd1) begin
          fire   = 1'b1;
          colour = slf_pkg::COL_BLUE;
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  assign req_o.push   = accept && fire;
  assign req_o.colour = colour;

  // Flip the phase and restart the interval on a flash toggle
  always_comb begin
    last_update_d = last_update_q;
    flash_phase_d = flash_phase_q;
    if (accept && toggle) begin
      last_update_d = in_data_i.timer_now;
      flash_phase_d = !flash_phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_update_q <= '0;
      flash_phase_q <= 1'b0;
    end else begin
      last_update_q <= last_update_d;
      flash_phase_q <= flash_phase_d;
    end
  end

  // Hold timing registers; write on a configuration beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_interval_q <= slf_pkg::DriveIntervalRst;
      emerg_on_wait_q  <= slf_pkg::EmergOnWaitRst;
      emerg_off_wait_q <= slf_pkg::EmergOffWaitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        slf_pkg::CFG_DRIVE_INTERVAL: drive_interval_q <= cfg_data_i;
        slf_pkg::CFG_EMERG_ON_WAIT:  emerg_on_wait_q  <= cfg_data_i;
        slf_pkg::CFG_EMERG_OFF_WAIT: emerg_off_wait_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/slf_queue.sv */
// ----------------------------------------------------------------------------
// slf_queue: short refresh queue
// Buffers pending refresh requests between the front and the back end.
// ----------------------------------------------------------------------------
module slf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slf_pkg::frame_req_t  req_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output slf_pkg::frame_head_t head_o
);

  slf_pkg::colour_e           mem_q [slf_pkg::QueueDepth];
  logic [slf_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [slf_pkg::QPtrW:0]    count_q, count_d;
  logic                       do_pop;

  assign full_o       = (count_q == (slf_pkg::QPtrW + 1)'(slf_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.colour = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (req_i.push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !req_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (req_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_ptr_q] <= req_i.colour;
    end
  end

endmodule

/* rtl/slf_back.sv */
// ----------------------------------------------------------------------------
// slf_back: frame sequencer
// Walks the strip one LED per cycle, while the output is not stalled, for the
// refresh at the queue head and drives the registered output beat.
// ----------------------------------------------------------------------------
module slf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slf_pkg::frame_head_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output slf_pkg::out_item_t    out_data_o
);

  localparam logic [slf_pkg::LedCntW-1:0] LastLed =
    slf_pkg::LedCntW'(slf_pkg::LedCount - 1);

  logic [slf_pkg::LedCntW-1:0] led_q;
  logic                        out_valid_q;
  slf_pkg::out_item_t          out_q;
  logic                        load;
  logic                        is_last;
  slf_pkg::grb_code_t          codes;

  assign load    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign is_last = (led_q == LastLed);
  assign pop_o   = load && is_last;
  assign codes   = slf_pkg::colour_codes(head_i.colour);

  // Advance the LED counter on each loaded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        led_q       <= is_last ? '0 : led_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.led_index  <= 6'(led_q);
      out_q.green_code <= codes.green;
      out_q.red_code   <= codes.red;
      out_q.blue_code  <= codes.blue;
      out_q.last_led   <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/status_light_flasher_ws2812.sv */
// ----------------------------------------------------------------------------
// status_light_flasher_ws2812: status light flasher for a WS2812 strip
// Turns mode and timer samples into encoded GRB words, one per LED.
// ----------------------------------------------------------------------------
// An input beat is taken whenever the queue is not full. A refresh puts
// one request into a two-entry queue and then occupies the output for
// LedCount LED words (eight by default), one LED word a cycle from the back
// end's LED counter while the output is not stalled. The front stalls input
// only while the queue is full, and keeps taking items while words of an
// earlier frame are still being sent.
// Timing registers are written through the cfg port (always ready) and
// should only change while no frame is pending.
module status_light_flasher_ws2812 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  slf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slf_pkg::out_item_t out_data_o
);

  slf_pkg::frame_req_t  req;
  slf_pkg::frame_head_t head;
  logic                 q_full;
  logic                 pop;

  assign cfg_ready_o = 1'b1;

  slf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .req_o       (req)
  );

  slf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  slf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/slf_checker.sv */
// ----------------------------------------------------------------------------
// slf_checker: port-level checks of the status light flasher
// Watches the output beats of the top level over time.
// ----------------------------------------------------------------------------
module slf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input slf_pkg::out_item_t out_data_o
);

  localparam logic [23:0] SymTop = 24'h924924;
  localparam logic [23:0] SymLow = 24'h249249;

  logic out_beat;
  assign out_beat = out_valid_o && !out_stall_i;

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Frame continues after a non-final word
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !out_data_o.last_led |=>
      out_valid_o && (out_data_o.led_index == $past(out_data_o.led_index) + 6'd1))
    else $error("frame word missing or out of order");

  // Final word carries the last index
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_led ==
      (out_data_o.led_index == 6'(slf_pkg::LedCount - 1))))
    else $error("last flag and LED index disagree");

  // Every symbol is 110 or 100
  a_symbols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.green_code & SymTop) == SymTop) &&
      ((out_data_o.green_code & SymLow) == 24'd0) &&
      ((out_data_o.red_code & SymTop) == SymTop) &&
      ((out_data_o.red_code & SymLow) == 24'd0) &&
      ((out_data_o.blue_code & SymTop) == SymTop) &&
      ((out_data_o.blue_code & SymLow) == 24'd0))
    else $error("malformed line symbol");

endmodule

bind status_light_flasher_ws2812 slf_checker u_slf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
